// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/bsc_pkg.sv
// Package: shared types and codes of the safety check unit
`default_nettype none
package bsc_pkg;
   localparam int AmountFields = 4;

   typedef enum logic [1:0] {
      CMD_LOAD_MAX   = 2'd0,
      CMD_LOAD_ALLOC = 2'd1,
      CMD_LOAD_AVAIL = 2'd2,
      CMD_REQUEST    = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_SAFE     = 2'd0,
      ST_UNSAFE   = 2'd1,
      ST_REJECTED = 2'd2
   } status_type;

   localparam logic CSR_PROCESS_COUNT  = 1'b0;
   localparam logic CSR_RESOURCE_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0]  command;
      logic [2:0]  process;
      logic [15:0] amount_0;
      logic [15:0] amount_1;
      logic [15:0] amount_2;
      logic [15:0] amount_3;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] order_process;
      logic       last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_max;      // write maximum row of the request's process
      logic load_alloc;
      logic load_avail;
      logic chk_begin;     // lane check of request, lane 0
      logic chk_step;      // check next lane
      logic grant_step;    // apply grant to one lane
      logic work_init;     // work := available, clear done
      logic scan_begin;    // invalidate best, start scan at process 0
      logic scan_step;     // evaluate one process
      logic test_step;     // test/update one lane of work
      logic commit;        // mark pick done
   } ctl_type;

   // Datapath to controller status
   typedef struct packed {
      logic lane_last;     // current lane is the last active one
      logic proc_last;     // current scan process is the last active one
      logic chk_fail;      // lane check failed
      logic bad_proc;      // request process out of range
      logic test_fail;     // work went negative
   } sts_type;
endpackage
`default_nettype wire

// File: rtl/bsc_datapath.sv
// Datapath: tables, work vector, need scan and lane tests
`default_nettype none
module bsc_datapath #(
   parameter int MAX_PROCESSES = 8,
   parameter int MAX_RESOURCES = 4,
   parameter int AMOUNT_BITS   = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire bsc_pkg::req_type req_ff_i,
   input  wire bsc_pkg::ctl_type ctl,
   input  wire logic [3:0]      pcount,
   input  wire logic [3:0]      rcount,
   output bsc_pkg::sts_type     sts,
   output logic [2:0]           pick_out
);
   import bsc_pkg::*;

   localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int SW = AMOUNT_BITS + RW + 2;   // signed need sum width
   localparam int WW = AMOUNT_BITS + PW + 2;   // signed work width

   logic [AMOUNT_BITS-1:0] max_ff [MAX_PROCESSES][MAX_RESOURCES];
   logic [AMOUNT_BITS-1:0] alloc_ff [MAX_PROCESSES][MAX_RESOURCES];
   logic [AMOUNT_BITS-1:0] avail_ff [MAX_RESOURCES];
   logic signed [WW-1:0]   work_ff [MAX_RESOURCES];
   logic [MAX_PROCESSES-1:0] done_ff;
   logic [RW:0]  lane_ff;
   logic [PW:0]  scan_ff;
   logic [PW-1:0] pick_ff;
   logic          have_ff;
   logic signed [SW-1:0] best_ff;

   logic [AMOUNT_BITS-1:0] req_amt [MAX_RESOURCES];
   logic [PW-1:0] proc_idx;
   logic [RW-1:0] lane_idx;
   logic [PW-1:0] scan_idx;
   logic signed [SW-1:0] need_sum;
   logic [AMOUNT_BITS:0] alloc_plus;
   logic [AMOUNT_BITS-1:0] avail_dec;
   logic signed [WW-1:0] work_sub;

   // request amounts per lane, masked to the amount width
   always_comb begin
      for (int r = 0; r < MAX_RESOURCES; r++) begin
         req_amt[r] = '0;
      end
      for (int r = 0; r < MAX_RESOURCES && r < AmountFields; r++) begin
         case (r)
            0: req_amt[r] = AMOUNT_BITS'({16'd0, req_ff_i.amount_0});
            1: req_amt[r] = AMOUNT_BITS'({16'd0, req_ff_i.amount_1});
            2: req_amt[r] = AMOUNT_BITS'({16'd0, req_ff_i.amount_2});
            default: req_amt[r] = AMOUNT_BITS'({16'd0, req_ff_i.amount_3});
         endcase
      end
   end

   assign proc_idx = PW'(req_ff_i.process);
   assign lane_idx = lane_ff[RW-1:0];
   assign scan_idx = scan_ff[PW-1:0];

   // summed need of the scanned process over active lanes
   always_comb begin
      need_sum = '0;
      for (int r = 0; r < MAX_RESOURCES; r++) begin
         if (r < 32'(rcount)) begin
            need_sum = need_sum + SW'($signed({1'b0, max_ff[scan_idx][r]}))
                       - SW'($signed({1'b0, alloc_ff[scan_idx][r]}));
         end
      end
   end

   assign alloc_plus = {1'b0, alloc_ff[proc_idx][lane_idx]} + {1'b0, req_amt[lane_idx]};
   assign avail_dec = avail_ff[lane_idx] - req_amt[lane_idx];
   assign work_sub = work_ff[lane_idx]
                     - WW'($signed({1'b0, max_ff[pick_ff][lane_idx]}))
                     + WW'($signed({1'b0, alloc_ff[pick_ff][lane_idx]}));

   // status toward the controller
   always_comb begin
      sts.lane_last = (32'(lane_ff) + 1 >= 32'(rcount));
      sts.proc_last = (32'(scan_ff) + 1 >= 32'(pcount));
      sts.chk_fail  = (req_amt[lane_idx] > avail_ff[lane_idx]) || alloc_plus[AMOUNT_BITS];
      sts.bad_proc  = (32'(req_ff_i.process) >= MAX_PROCESSES);
      sts.test_fail = work_sub[WW-1];
   end
   assign pick_out = 3'(pick_ff);

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < MAX_PROCESSES; p++) begin
            for (int r = 0; r < MAX_RESOURCES; r++) begin
               max_ff[p][r]   <= '0;
               alloc_ff[p][r] <= '0;
            end
         end
         for (int r = 0; r < MAX_RESOURCES; r++) begin
            avail_ff[r] <= '0;
         end
         done_ff <= '0;
         lane_ff <= '0;
         scan_ff <= '0;
         have_ff <= 1'b0;
      end else begin
         if (ctl.load_max && !sts.bad_proc) begin
            for (int r = 0; r < MAX_RESOURCES; r++) max_ff[proc_idx][r] <= req_amt[r];
         end
         if (ctl.load_alloc && !sts.bad_proc) begin
            for (int r = 0; r < MAX_RESOURCES; r++) alloc_ff[proc_idx][r] <= req_amt[r];
         end
         if (ctl.load_avail) begin
            for (int r = 0; r < MAX_RESOURCES; r++) avail_ff[r] <= req_amt[r];
         end
         // lane counter: restart wins over advance
         if (ctl.chk_begin || ctl.scan_begin) begin
            lane_ff <= '0;
         end else if (ctl.chk_step || ctl.grant_step || ctl.test_step) begin
            lane_ff <= lane_ff + 1'b1;
         end
         if (ctl.grant_step) begin
            alloc_ff[proc_idx][lane_idx] <= alloc_plus[AMOUNT_BITS-1:0];
            avail_ff[lane_idx] <= avail_dec;
         end
         // work starts from available, including the lane granted this cycle
         if (ctl.work_init) begin
            for (int r = 0; r < MAX_RESOURCES; r++) begin
               if (ctl.grant_step && r == 32'(lane_idx)) begin
                  work_ff[r] <= WW'($signed({1'b0, avail_dec}));
               end else begin
                  work_ff[r] <= WW'($signed({1'b0, avail_ff[r]}));
               end
            end
            done_ff <= '0;
         end
         if (ctl.scan_begin) begin
            scan_ff <= '0;
            have_ff <= 1'b0;
         end
         if (ctl.scan_step) begin
            if (!done_ff[scan_idx] && (!have_ff || need_sum < best_ff)) begin
               have_ff <= 1'b1;
               best_ff <= need_sum;
               pick_ff <= scan_idx;
            end
            scan_ff <= scan_ff + 1'b1;
         end
         if (ctl.test_step) begin
            work_ff[lane_idx] <= work_sub + WW'($signed({1'b0, alloc_ff[pick_ff][lane_idx]}))
                                 + WW'($signed({1'b0, max_ff[pick_ff][lane_idx]}))
                                 - WW'($signed({1'b0, alloc_ff[pick_ff][lane_idx]}));
         end
         if (ctl.commit) done_ff[pick_ff] <= 1'b1;
      end
   end
endmodule
`default_nettype wire

// File: rtl/bsc_controller.sv
// Controller: sequences loads, request checks, grant and safety rounds
`default_nettype none
module bsc_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire bsc_pkg::command_type cmd,
   input  wire bsc_pkg::sts_type sts,
   input  wire logic [2:0]       pick,
   input  wire logic [3:0]       pcount,
   output logic                  busy,
   output bsc_pkg::ctl_type      ctl,
   output logic                  accept,
   output logic                  rsp_valid,
   output bsc_pkg::rsp_type      rsp
);
   import bsc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_CHECK, S_GRANT, S_SCAN, S_TEST, S_EMIT
   } state_type;

   state_type state_ff;
   logic [2:0] order_ff [16];   // one entry per value of the 4-bit step counter
   logic [3:0] step_ff;
   logic [3:0] emit_ff;
   logic       rv_ff;
   rsp_type    rsp_ff;

   assign busy = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign rsp_valid = rv_ff;
   assign rsp = rsp_ff;

   // commands decoded from state and status
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         S_IDLE:   ;
         S_DECODE: begin
            ctl.load_max   = (cmd == CMD_LOAD_MAX);
            ctl.load_alloc = (cmd == CMD_LOAD_ALLOC);
            ctl.load_avail = (cmd == CMD_LOAD_AVAIL);
            ctl.chk_begin  = 1'b1;
         end
         S_CHECK:  begin
            ctl.chk_step  = !sts.chk_fail && !sts.lane_last;
            ctl.chk_begin = !sts.chk_fail && sts.lane_last;
         end
         S_GRANT:  begin
            ctl.grant_step = 1'b1;
            ctl.work_init  = sts.lane_last;
            ctl.scan_begin = sts.lane_last;
         end
         S_SCAN:   ctl.scan_step = 1'b1;
         S_TEST:   begin
            ctl.test_step  = !sts.test_fail;
            ctl.commit     = !sts.test_fail && sts.lane_last;
            ctl.scan_begin = !sts.test_fail && sts.lane_last;
         end
         S_EMIT:   ;
         default:  ;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         step_ff  <= '0;
         emit_ff  <= '0;
      end else begin
         rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (start) state_ff <= S_DECODE;
            S_DECODE: begin
               if (cmd != CMD_REQUEST) begin
                  state_ff <= S_IDLE;
               end else if (sts.bad_proc) begin
                  rv_ff <= 1'b1;
                  rsp_ff <= '{status: ST_REJECTED, order_process: 3'd0, last: 1'b1};
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (sts.chk_fail) begin
                  rv_ff <= 1'b1;
                  rsp_ff <= '{status: ST_REJECTED, order_process: 3'd0, last: 1'b1};
                  state_ff <= S_IDLE;
               end else if (sts.lane_last) begin
                  state_ff <= S_GRANT;
               end
            end
            S_GRANT: if (sts.lane_last) begin
               step_ff  <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: if (sts.proc_last) state_ff <= S_TEST;
            S_TEST: begin
               if (sts.test_fail) begin
                  rv_ff <= 1'b1;
                  rsp_ff <= '{status: ST_UNSAFE, order_process: 3'd0, last: 1'b1};
                  state_ff <= S_IDLE;
               end else if (sts.lane_last) begin
                  order_ff[step_ff] <= pick;
                  step_ff <= step_ff + 1'b1;
                  if (step_ff + 1'b1 >= pcount) begin
                     emit_ff  <= '0;
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_EMIT: begin
               rv_ff <= 1'b1;
               rsp_ff <= '{status: ST_SAFE, order_process: order_ff[emit_ff],
                           last: (emit_ff + 1'b1 >= pcount)};
               emit_ff <= emit_ff + 1'b1;
               if (emit_ff + 1'b1 >= pcount) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: rtl/bankers_safety_check_unit.sv
// Top level: request capture, configuration registers, controller and datapath
//
// Banker's-style safety check unit. A request is taken when start is high and
// busy low; loads keep busy high for one cycle and give no result. A resource
// request checks one lane a cycle, grants one lane a cycle, then runs
// process_count rounds, each scanning process_count processes one per cycle and
// testing one lane per cycle, then emits the safe order one entry a cycle: the
// final result shows in the first cycle busy is low again. Rejects and unsafe
// results come out earlier. Results appear on rsp_valid for one cycle each and
// cannot be held off.
`default_nettype none
`include "assert_macros.svh"
module bankers_safety_check_unit #(
   parameter int MAX_PROCESSES = 8,
   parameter int MAX_RESOURCES = 4,
   parameter int AMOUNT_BITS   = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bsc_pkg::req_type req_data,
   output logic                  rsp_valid,
   output bsc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write,
   input  wire logic             csr_index,
   input  wire logic [3:0]       csr_data
);
   import bsc_pkg::*;

   req_type req_ff;
   logic [3:0] pcount_ff, rcount_ff;
   ctl_type ctl;
   sts_type sts;
   logic [2:0] pick;
   logic accept;

   // capture the request
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
   end

   // configuration registers, clamped on write
   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= 4'(MAX_PROCESSES > 8 ? 8 : MAX_PROCESSES);
         rcount_ff <= 4'(MAX_RESOURCES > 4 ? 4 : MAX_RESOURCES);
      end else if (csr_write) begin
         if (csr_index == CSR_PROCESS_COUNT) begin
            if (csr_data == 4'd0) pcount_ff <= 4'd1;
            else if (32'(csr_data) > MAX_PROCESSES) pcount_ff <= 4'(MAX_PROCESSES);
            else pcount_ff <= csr_data;
         end else begin
            if (csr_data[2:0] == 3'd0) rcount_ff <= 4'd1;
            else if (32'(csr_data[2:0]) > MAX_RESOURCES) rcount_ff <= 4'(MAX_RESOURCES);
            else rcount_ff <= {1'b0, csr_data[2:0]};
         end
      end
   end

   bsc_controller u_ctrl (
      .clock, .reset, .start, .cmd(command_type'(req_ff.command)), .sts, .pick,
      .pcount(pcount_ff), .busy, .ctl, .accept, .rsp_valid, .rsp(rsp_data)
   );

   bsc_datapath #(
      .MAX_PROCESSES(MAX_PROCESSES), .MAX_RESOURCES(MAX_RESOURCES),
      .AMOUNT_BITS(AMOUNT_BITS)
   ) u_dp (
      .clock, .reset, .req_ff_i(req_ff), .ctl, .pcount(pcount_ff),
      .rcount(rcount_ff), .sts, .pick_out(pick)
   );

   `ASSERT_IMPLIES(a_rsp_busy, clock, reset, rsp_valid && rsp_data.last, !busy)
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `ASSERT_IMPLIES(a_status_ok, clock, reset, rsp_valid, rsp_data.status <= ST_REJECTED)
endmodule
`default_nettype wire

// File: bench/bankers_safety_check_unit_tb.sv
// Testbench for the banker's safety check unit: random and directed requests against a predictor
`timescale 1ns / 100ps
`default_nettype none
module bankers_safety_check_unit_tb;
   import bsc_pkg::*;

   localparam int NPROC = 8;
   localparam int NRES = 4;
   localparam int DRAIN_CYCLES = 200;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_write;
   logic csr_index;
   logic [3:0] csr_data;

   bankers_safety_check_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   logic [15:0] max_rows [NPROC][NRES];
   logic [15:0] alloc_rows [NPROC][NRES];
   logic [15:0] avail_lanes [NRES];
   int unsigned active_procs;
   int unsigned active_lanes;

   req_type pending_requests [$];
   rsp_type expected_results [$];
   int errors;
   bit quiet_phase;
   int gap_left;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAILURE");
      $finish;
   end

   function automatic void predictor_reset();
      for (int p = 0; p < NPROC; p++)
         for (int r = 0; r < NRES; r++) begin
            max_rows[p][r] = '0;
            alloc_rows[p][r] = '0;
         end
      for (int r = 0; r < NRES; r++) avail_lanes[r] = '0;
      active_procs = NPROC;
      active_lanes = NRES;
   endfunction

   function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void push_result(status_type st, int unsigned p, bit lst);
      rsp_type r;
      r.status = st;
      r.order_process = p[2:0];
      r.last = lst;
      expected_results.push_back(r);
   endfunction

   // compute results of one accepted request and update tables
   function automatic void predict_request(req_type rq);
      logic [15:0] amt [NRES];
      longint work [NRES];
      bit done [NPROC];
      int unsigned order [NPROC];
      int unsigned pick;
      bit have;
      bit safe;
      longint best;
      longint s;
      amt[0] = rq.amount_0;
      amt[1] = rq.amount_1;
      amt[2] = rq.amount_2;
      amt[3] = rq.amount_3;
      case (command_type'(rq.command))
         CMD_LOAD_AVAIL: begin
            for (int r = 0; r < NRES; r++) avail_lanes[r] = amt[r];
         end
         CMD_LOAD_MAX: begin
            for (int r = 0; r < NRES; r++) max_rows[rq.process][r] = amt[r];
         end
         CMD_LOAD_ALLOC: begin
            for (int r = 0; r < NRES; r++) alloc_rows[rq.process][r] = amt[r];
         end
         default: begin
            for (int r = 0; r < active_lanes; r++)
               if (amt[r] > avail_lanes[r] ||
                   32'(alloc_rows[rq.process][r]) + 32'(amt[r]) > 32'hFFFF) begin
                  push_result(ST_REJECTED, 0, 1'b1);
                  return;
               end
            for (int r = 0; r < active_lanes; r++) begin
               alloc_rows[rq.process][r] += amt[r];
               avail_lanes[r] -= amt[r];
            end
            for (int r = 0; r < NRES; r++) work[r] = avail_lanes[r];
            for (int p = 0; p < NPROC; p++) done[p] = 1'b0;
            safe = 1'b1;
            for (int step = 0; step < active_procs && safe; step++) begin
               have = 1'b0;
               pick = 0;
               best = 0;
               for (int p = 0; p < active_procs; p++) begin
                  if (done[p]) continue;
                  s = 0;
                  for (int r = 0; r < active_lanes; r++)
                     s += longint'(max_rows[p][r]) - longint'(alloc_rows[p][r]);
                  if (!have || s < best) begin
                     have = 1'b1;
                     best = s;
                     pick = p;
                  end
               end
               for (int r = 0; r < active_lanes && safe; r++) begin
                  work[r] -= longint'(max_rows[pick][r]) - longint'(alloc_rows[pick][r]);
                  if (work[r] < 0) safe = 1'b0;
               end
               if (safe) begin
                  for (int r = 0; r < active_lanes; r++) work[r] += max_rows[pick][r];
                  done[pick] = 1'b1;
                  order[step] = pick;
               end
            end
            if (!safe) push_result(ST_UNSAFE, 0, 1'b1);
            else
               for (int i = 0; i < active_procs; i++)
                  push_result(ST_SAFE, order[i], i + 1 == active_procs);
         end
      endcase
   endfunction

   function automatic req_type make_request(command_type c, int unsigned p,
                                            int unsigned a0, int unsigned a1,
                                            int unsigned a2, int unsigned a3);
      req_type rq;
      rq.command = c;
      rq.process = p[2:0];
      rq.amount_0 = a0[15:0];
      rq.amount_1 = a1[15:0];
      rq.amount_2 = a2[15:0];
      rq.amount_3 = a3[15:0];
      return rq;
   endfunction

   // amounts biased small so grants and safe orders are common
   function automatic int unsigned pick_amount(int unsigned scale);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 65535);
         1: return 65535;
         2: return 0;
         default: return $urandom_range(0, scale);
      endcase
   endfunction

   function automatic req_type random_row(command_type c, int unsigned scale);
      return make_request(c, $urandom_range(0, 7), pick_amount(scale), pick_amount(scale),
                          pick_amount(scale), pick_amount(scale));
   endfunction

   // driver: one request per accept, random idle bursts
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !busy) begin
         predict_request(req_data);
         void'(pending_requests.pop_front());
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            gap_left <= $urandom_range(1, 7);
         end else if (pending_requests.size() > 0) begin
            start <= 1'b1;
            req_data <= pending_requests[0];
         end else
            start <= 1'b0;
      end else if (!start) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else if (pending_requests.size() > 0) begin
            start <= 1'b1;
            req_data <= pending_requests[0];
         end
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%t unexpected result: expected none, actual %p", $time, rsp_data);
            errors++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_data.status !== exp_r.status ||
                rsp_data.order_process !== exp_r.order_process ||
                rsp_data.last !== exp_r.last) begin
               $display("%t mismatch: expected %p, actual %p", $time, exp_r, rsp_data);
               errors++;
            end
         end
      end
   end

   task automatic write_csr(logic idx, logic [3:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_PROCESS_COUNT) active_procs = clamp_count(val, NPROC);
      else active_lanes = clamp_count(val & 4'h7, NRES);
   endtask

   // let queued requests drain, then settle for a late loading operation
   task automatic wait_idle();
      int guard;
      guard = 0;
      while ((pending_requests.size() > 0 || start || expected_results.size() > 0)
             && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one phase of well-formed scenarios with random content plus noise
   task automatic random_phase(int n);
      int unsigned scale;
      for (int i = 0; i < n; i++) begin
         scale = ($urandom_range(0, 1) == 0) ? 15 : 300;
         case ($urandom_range(0, 9))
            0: pending_requests.push_back(make_request(CMD_LOAD_AVAIL, $urandom_range(0, 7),
                  $urandom_range(0, 4 * scale), $urandom_range(0, 4 * scale),
                  $urandom_range(0, 4 * scale), pick_amount(4 * scale)));
            1, 2: pending_requests.push_back(random_row(CMD_LOAD_MAX, scale));
            3: pending_requests.push_back(random_row(CMD_LOAD_ALLOC, scale / 4));
            default: pending_requests.push_back(make_request(CMD_REQUEST,
                  $urandom_range(0, 7), $urandom_range(0, scale / 8),
                  $urandom_range(0, scale / 8), $urandom_range(0, scale / 8),
                  pick_amount(scale / 8)));
         endcase
      end
   endtask

   initial begin
      errors = 0;
      quiet_phase = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = CSR_PROCESS_COUNT;
      csr_data = '0;
      predictor_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: request on empty tables, extremes, overflow and reject
      pending_requests.push_back(make_request(CMD_REQUEST, 0, 0, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_REQUEST, 7, 1, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_LOAD_AVAIL, 0, 65535, 65535, 65535, 65535));
      pending_requests.push_back(make_request(CMD_LOAD_ALLOC, 7, 65535, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_REQUEST, 7, 1, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_LOAD_MAX, 3, 65535, 65535, 65535, 65535));
      pending_requests.push_back(make_request(CMD_REQUEST, 3, 0, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_LOAD_MAX, 3, 10, 10, 10, 10));
      pending_requests.push_back(make_request(CMD_LOAD_MAX, 5, 2, 2, 2, 2));
      pending_requests.push_back(make_request(CMD_LOAD_ALLOC, 7, 0, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_REQUEST, 5, 1, 1, 1, 1));
      pending_requests.push_back(make_request(CMD_LOAD_AVAIL, 0, 3, 3, 3, 3));
      pending_requests.push_back(make_request(CMD_REQUEST, 2, 0, 0, 0, 4));
      pending_requests.push_back(make_request(CMD_LOAD_ALLOC, 6, 65535, 65535, 65535, 65535));
      pending_requests.push_back(make_request(CMD_REQUEST, 6, 0, 0, 0, 0));
      pending_requests.push_back(make_request(CMD_REQUEST, 1, 3, 3, 3, 3));
      wait_idle();

      // inactive lanes and processes, register saturation at both ends
      write_csr(CSR_RESOURCE_COUNT, 4'd0);
      write_csr(CSR_PROCESS_COUNT, 4'd0);
      pending_requests.push_back(make_request(CMD_REQUEST, 6, 0, 65535, 65535, 65535));
      pending_requests.push_back(make_request(CMD_REQUEST, 0, 0, 0, 0, 0));
      wait_idle();
      write_csr(CSR_PROCESS_COUNT, 4'd15);
      write_csr(CSR_RESOURCE_COUNT, 4'd7);
      pending_requests.push_back(make_request(CMD_REQUEST, 4, 0, 0, 0, 0));
      wait_idle();

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_PROCESS_COUNT, (ph == 0) ? 4'd8 : 4'($urandom_range(0, 15)));
         write_csr(CSR_RESOURCE_COUNT, (ph == 1) ? 4'd1 : 4'($urandom_range(0, 7)));
         quiet_phase = (ph == 5);
         random_phase(52);
         wait_idle();
      end

      if (errors == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire
